/* design/wfc_pkg.sv */
// Package for the word frequency counter: state type, sizes and separator test.
`timescale 1ns / 1ps
package wfc_pkg;

    localparam int unsigned CNT_W   = 16;
    localparam int unsigned IDX_W   = 5;
    localparam int unsigned LEN_W   = 5;
    localparam int unsigned OUT_W   = 32;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_EXCL  = 8'h21;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CMP,
        S_LRD,
        S_LGET,
        S_OUT
    } t_state;

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_COMMA) || (c == CH_COLON) ||
               (c == CH_QUOTE) || (c == CH_QMARK) || (c == CH_EXCL) ||
               (c == CH_DOT);
    endfunction

endpackage

/* design/word_frequency_counter.sv */
// Timing: a text byte is taken while idle; at a word end the sequencer alternates S_SCAN and S_CMP
// for each entry compared, with a final S_SCAN when no entry matches, then waits in S_OUT for the sink.
// End of text lists each entry through S_LRD, S_LGET and S_OUT, waiting in S_OUT for the sink.
// Throughput: one byte per cycle inside a word; no byte is taken while a word end is in progress.
// Reset (synchronous, active low) empties the table and the open word; stored
// contents are not cleared, the entry count alone marks them.
`timescale 1ns / 1ps
module word_frequency_counter
    import wfc_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 32,
    parameter int unsigned WORD_BYTES  = 19
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] text_byte
    input  logic             s_axis_tuser,   // [0] kind
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // [4:0] entry_index, [20:5] occurrences,
                                             // [21] is_new, [22] dropped_full,
                                             // [23] truncated, [28:24] word_length
    output logic             m_axis_tuser,   // [0] is_listing
    output logic             m_axis_tlast    // last
);

    localparam int unsigned ROW_W = WORD_BYTES * 8;
    localparam int unsigned LW    = $clog2(WORD_BYTES + 1);
    localparam int unsigned UW    = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    t_state r_state, n_state;

    logic [ROW_W-1:0] r_pword, n_pword;
    logic [LW-1:0]    r_plen, n_plen;
    logic             r_pcut, n_pcut;
    logic [UW-1:0]    r_used, n_used;
    logic [UW-1:0]    r_idx, n_idx;
    logic             r_eot, n_eot;

    logic [IDX_W-1:0] r_o_idx, n_o_idx;
    logic [CNT_W-1:0] r_o_cnt, n_o_cnt;
    logic             r_o_new, n_o_new;
    logic             r_o_drop, n_o_drop;
    logic             r_o_cut, n_o_cut;
    logic [LEN_W-1:0] r_o_len, n_o_len;
    logic             r_o_list, n_o_list;
    logic             r_o_last, n_o_last;

    logic [ROW_W-1:0] rd_row;
    logic [LW-1:0]    rd_len;
    logic [CNT_W-1:0] rd_cnt;
    logic [AW-1:0]    wr_addr;
    logic             wr_row, wr_cnt;
    logic [CNT_W-1:0] wr_cnt_data;
    logic [ROW_W-1:0] len_mask;
    logic             hit;
    logic             in_beat;

    wfc_store #(
        .DEPTH (TABLE_DEPTH),
        .ROW_W (ROW_W),
        .LW    (LW),
        .CW    (CNT_W),
        .AW    (AW)
    ) u_store (
        .i_clk         (i_clk),
        .i_rd_addr     (r_idx[AW-1:0]),
        .o_rd_row      (rd_row),
        .o_rd_len      (rd_len),
        .o_rd_cnt      (rd_cnt),
        .i_wr_addr     (wr_addr),
        .i_wr_row      (wr_row),
        .i_wr_row_data (r_pword),
        .i_wr_len      (r_plen),
        .i_wr_cnt      (wr_cnt),
        .i_wr_cnt_data (wr_cnt_data)
    );

    // Mask off bytes past the open word's length
    always_comb begin
        for (int k = 0; k < WORD_BYTES; k++) begin
            len_mask[k*8 +: 8] = (LW'(k) < r_plen) ? 8'hFF : 8'h00;
        end
    end

    assign hit = (rd_len == r_plen) && (((rd_row ^ r_pword) & len_mask) == '0);

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {3'b000, r_o_len, r_o_cut, r_o_drop, r_o_new, r_o_cnt, r_o_idx};
    assign m_axis_tuser  = r_o_list;
    assign m_axis_tlast  = r_o_last;

    // Hold state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_plen  <= '0;
            r_pcut  <= 1'b0;
            r_used  <= '0;
            r_idx   <= '0;
            r_eot   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_plen  <= n_plen;
            r_pcut  <= n_pcut;
            r_used  <= n_used;
            r_idx   <= n_idx;
            r_eot   <= n_eot;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pword  <= n_pword;
        r_o_idx  <= n_o_idx;
        r_o_cnt  <= n_o_cnt;
        r_o_new  <= n_o_new;
        r_o_drop <= n_o_drop;
        r_o_cut  <= n_o_cut;
        r_o_len  <= n_o_len;
        r_o_list <= n_o_list;
        r_o_last <= n_o_last;
    end

    // Sequencer: take bytes, scan the table, list at end of text
    always_comb begin
        n_state     = r_state;
        n_pword     = r_pword;
        n_plen      = r_plen;
        n_pcut      = r_pcut;
        n_used      = r_used;
        n_idx       = r_idx;
        n_eot       = r_eot;
        n_o_idx     = r_o_idx;
        n_o_cnt     = r_o_cnt;
        n_o_new     = r_o_new;
        n_o_drop    = r_o_drop;
        n_o_cut     = r_o_cut;
        n_o_len     = r_o_len;
        n_o_list    = r_o_list;
        n_o_last    = r_o_last;
        wr_addr     = r_idx[AW-1:0];
        wr_row      = 1'b0;
        wr_cnt      = 1'b0;
        wr_cnt_data = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + 1'b1;

        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_idx = '0;
                    if (!s_axis_tuser && !is_sep(s_axis_tdata)) begin
                        // Append a byte, or flag the cut past the last slot
                        if (r_plen < LW'(WORD_BYTES)) begin
                            for (int k = 0; k < WORD_BYTES; k++) begin
                                if (LW'(k) == r_plen) begin
                                    n_pword[k*8 +: 8] = s_axis_tdata;
                                end
                            end
                            n_plen = r_plen + 1'b1;
                        end else begin
                            n_pcut = 1'b1;
                        end
                    end else begin
                        n_eot = s_axis_tuser;
                        if (r_plen != '0) begin
                            n_state = S_SCAN;
                        end else begin
                            n_pcut = 1'b0;
                            if (s_axis_tuser && (r_used != '0)) begin
                                n_state = S_LRD;
                            end
                        end
                    end
                end
            end
            S_SCAN: begin
                n_o_cut  = r_pcut;
                n_o_len  = LEN_W'(r_plen);
                n_o_list = 1'b0;
                n_o_last = !r_eot;
                n_o_new  = 1'b0;
                n_o_drop = 1'b0;
                if (r_idx == r_used) begin
                    // No match: store the word or drop it when full
                    n_plen  = '0;
                    n_pcut  = 1'b0;
                    n_state = S_OUT;
                    if (r_used >= UW'(TABLE_DEPTH)) begin
                        n_o_drop = 1'b1;
                        n_o_idx  = '0;
                        n_o_cnt  = '0;
                    end else begin
                        wr_addr     = r_used[AW-1:0];
                        wr_row      = 1'b1;
                        wr_cnt      = 1'b1;
                        wr_cnt_data = CNT_W'(1);
                        n_o_new     = 1'b1;
                        n_o_idx     = IDX_W'(r_used);
                        n_o_cnt     = CNT_W'(1);
                        n_used      = r_used + 1'b1;
                    end
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (hit) begin
                    // Bump the matched entry's count
                    wr_cnt  = 1'b1;
                    n_o_idx = IDX_W'(r_idx);
                    n_o_cnt = wr_cnt_data;
                    n_plen  = '0;
                    n_pcut  = 1'b0;
                    n_state = S_OUT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_LRD: begin
                n_state = S_LGET;
            end
            S_LGET: begin
                n_o_idx  = IDX_W'(r_idx);
                n_o_cnt  = rd_cnt;
                n_o_new  = 1'b0;
                n_o_drop = 1'b0;
                n_o_cut  = 1'b0;
                n_o_len  = LEN_W'(rd_len);
                n_o_list = 1'b1;
                n_o_last = (r_idx == r_used - 1'b1);
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    if (r_o_list) begin
                        if (r_o_last) begin
                            n_used  = '0;
                            n_plen  = '0;
                            n_pcut  = 1'b0;
                            n_state = S_IDLE;
                        end else begin
                            n_idx   = r_idx + 1'b1;
                            n_state = S_LRD;
                        end
                    end else if (r_eot) begin
                        n_idx   = '0;
                        n_state = S_LRD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* design/wfc_store.sv */
// Entry table memories: stored words, lengths and counts with registered reads.
`timescale 1ns / 1ps
module wfc_store #(
    parameter int unsigned DEPTH  = 32,
    parameter int unsigned ROW_W  = 152,
    parameter int unsigned LW     = 5,
    parameter int unsigned CW     = 16,
    parameter int unsigned AW     = 5
) (
    input  logic             i_clk,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [ROW_W-1:0] o_rd_row,
    output logic [LW-1:0]    o_rd_len,
    output logic [CW-1:0]    o_rd_cnt,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic             i_wr_row,
    input  logic [ROW_W-1:0] i_wr_row_data,
    input  logic [LW-1:0]    i_wr_len,
    input  logic             i_wr_cnt,
    input  logic [CW-1:0]    i_wr_cnt_data
);

    logic [ROW_W-1:0] r_rows [DEPTH];
    logic [LW-1:0]    r_lens [DEPTH];
    logic [CW-1:0]    r_cnts [DEPTH];

    // Write word and length together, count on its own
    always_ff @(posedge i_clk) begin
        if (i_wr_row) begin
            r_rows[i_wr_addr] <= i_wr_row_data;
            r_lens[i_wr_addr] <= i_wr_len;
        end
        if (i_wr_cnt) begin
            r_cnts[i_wr_addr] <= i_wr_cnt_data;
        end
    end

    // Read one entry per cycle
    always_ff @(posedge i_clk) begin
        o_rd_row <= r_rows[i_rd_addr];
        o_rd_len <= r_lens[i_rd_addr];
        o_rd_cnt <= r_cnts[i_rd_addr];
    end

endmodule
